// ===== src/smpq_pkg.sv =====
// smpq_pkg: types, codes and constants for the sorted minimum priority queue
// used by smpq_cell and sorted_min_priority_queue_top; no dependencies

package smpq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int CAP_W         = 5;
    localparam int VALUE_W       = 32;
    localparam int PRIO_W        = 8;
    localparam int STATUS_W      = 2;
    localparam int FILL_W        = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

    typedef struct packed {
        logic                      op;
        logic signed [VALUE_W-1:0] item_value;
        logic [PRIO_W-1:0]         item_priority;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] out_value;
        logic [PRIO_W-1:0]         out_priority;
        logic [FILL_W-1:0]         fill_count;
    } t_out_word;

    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
    } t_entry;

    typedef struct packed {
        logic                      enq;
        logic                      deq;
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
    } t_cell_ctl;

endpackage

// ===== src/smpq_cell.sv =====
// smpq_cell: one slot of the sorted queue; holds an entry and trades it with neighbors
// depends on smpq_pkg

module smpq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  smpq_pkg::t_cell_ctl i_ctl,
    input  smpq_pkg::t_entry    i_left,
    input  logic               i_left_gt,
    input  smpq_pkg::t_entry    i_right,
    output smpq_pkg::t_entry    o_entry,
    output logic               o_gt
);

    smpq_pkg::t_entry r_entry;
    smpq_pkg::t_entry n_entry;

    // empty slot sorts after everything
    assign o_gt    = !r_entry.valid || (r_entry.prio > i_ctl.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.enq) begin
            if (i_left_gt) begin
                n_entry = i_left;
            end else if (o_gt) begin
                n_entry.valid = 1'b1;
                n_entry.value = i_ctl.value;
                n_entry.prio  = i_ctl.prio;
            end
        end else if (i_ctl.deq) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.value <= n_entry.value;
        r_entry.prio  <= n_entry.prio;
    end

endmodule

// ===== src/sorted_min_priority_queue_top.sv =====
// sorted_min_priority_queue_top: row of smpq_cell slots kept in ascending priority order
// depends on smpq_pkg and smpq_cell

// One word per cycle unless the output stalls: for every enqueue or dequeue all slots
// compare against the new priority in parallel and shift by one toward their neighbor,
// so the front slot always holds the lowest priority (earliest among equals). The result
// word sits in an output register, shown in the cycle after the input is accepted;
// a new word is taken while that register is empty or being taken. Capacity above DEPTH
// is treated as DEPTH; a lowered capacity keeps held entries.
module sorted_min_priority_queue_top #(
    parameter int DEPTH = smpq_pkg::DEPTH_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  smpq_pkg::t_in_word            i_word,
    output logic                          o_valid,
    input  logic                          i_stall,
    output smpq_pkg::t_out_word           o_word,
    input  logic                          i_cfg_we,
    input  logic [smpq_pkg::CAP_W-1:0]    i_cfg_wdata
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > smpq_pkg::FILL_W) ? CNT_W : smpq_pkg::FILL_W;

    logic [smpq_pkg::CAP_W-1:0] r_cap;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic                       r_out_valid;
    smpq_pkg::t_out_word        r_out;
    smpq_pkg::t_out_word        n_out;

    smpq_pkg::t_entry   w_entry [DEPTH];
    logic               w_gt    [DEPTH];
    smpq_pkg::t_cell_ctl w_ctl;

    logic             w_accept;
    logic [CMP_W-1:0] w_count_ext;
    logic [CMP_W-1:0] w_cap_ext;
    logic [CMP_W-1:0] w_count_next_ext;
    logic             w_full;
    logic             w_empty;

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    assign w_count_ext = CMP_W'(r_count);
    assign w_cap_ext   = CMP_W'(r_cap);
    assign w_full      = (w_count_ext >= w_cap_ext) || (w_count_ext >= CMP_W'(DEPTH));
    assign w_empty     = (r_count == '0);

    always_comb begin
        w_ctl.enq   = w_accept && (i_word.op == smpq_pkg::OP_ENQ) && !w_full;
        w_ctl.deq   = w_accept && (i_word.op == smpq_pkg::OP_DEQ) && !w_empty;
        w_ctl.value = i_word.item_value;
        w_ctl.prio  = i_word.item_priority;
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            smpq_pkg::t_entry w_left;
            smpq_pkg::t_entry w_right;
            logic             w_left_gt;
            if (g == 0) begin : g_first
                assign w_left    = '0;
                assign w_left_gt = 1'b0;
            end else begin : g_mid
                assign w_left    = w_entry[g-1];
                assign w_left_gt = w_gt[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_inner
                assign w_right = w_entry[g+1];
            end
            smpq_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_ctl),
                .i_left    (w_left),
                .i_left_gt (w_left_gt),
                .i_right   (w_right),
                .o_entry   (w_entry[g]),
                .o_gt      (w_gt[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_ctl.enq) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.deq) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign w_count_next_ext = CMP_W'(n_count);

    always_comb begin
        n_out.status       = smpq_pkg::ST_DONE;
        n_out.out_value    = '0;
        n_out.out_priority = '0;
        n_out.fill_count   = w_count_next_ext[smpq_pkg::FILL_W-1:0];
        if (i_word.op == smpq_pkg::OP_ENQ) begin
            if (w_full) begin
                n_out.status = smpq_pkg::ST_OVERFLOW;
            end
        end else if (w_empty) begin
            n_out.status = smpq_pkg::ST_EMPTY;
        end else begin
            n_out.out_value    = w_entry[0].value;
            n_out.out_priority = w_entry[0].prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= smpq_pkg::CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

endmodule
